// ----- rtl/core/hvn_pkg.sv -----
// Shared types and constants for the heightfield vertex normal block.
package hvn_pkg;

   localparam int HEIGHT_BITS = 16;
   localparam int INDEX_BITS  = 12;
   localparam int DIM_W       = 13;
   localparam int SPACE_W     = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int COMP_W      = 16;

   localparam int DZ_W     = HEIGHT_BITS + 1;
   localparam int IX_W     = HEIGHT_BITS + 5;
   localparam int PROD_W   = IX_W + SPACE_W + 1;
   localparam int MAG_W    = IX_W + SPACE_W - 1;
   localparam int NORM_W   = 30;
   localparam int SHIFT_W  = $clog2(MAG_W - NORM_W + 1);
   localparam int SQR_W    = 2 * NORM_W;
   localparam int SUMSQ_W  = SQR_W + 2;
   localparam int ROOT_W   = NORM_W + 1;
   localparam int RT_W     = 64;
   localparam int SQ_STEPS = 32;
   localparam int Q_W      = 16;
   localparam int NUM_W    = NORM_W + Q_W + 1;
   localparam int CNT_W    = 3;

   localparam logic [DIM_W-1:0]   RESET_COLUMNS = DIM_W'(256);
   localparam logic [DIM_W-1:0]   RESET_ROWS    = DIM_W'(256);
   localparam logic [SPACE_W-1:0] RESET_SPACING = SPACE_W'(1);
   localparam logic [Q_W-2:0]     Q15_MAX       = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMNS   = 2'd0,
      CSR_ROWS      = 2'd1,
      CSR_SPACING_X = 2'd2,
      CSR_SPACING_Y = 2'd3
   } csr_index_type;

   // side data carried through the square-root stages
   typedef struct packed {
      logic              outside;
      logic [1:0]        neg;
      logic [NORM_W-1:0] mag_x;
      logic [NORM_W-1:0] mag_y;
      logic [NORM_W-1:0] mag_z;
   } sq_side_type;

   // side data carried through the divider stages
   typedef struct packed {
      logic              outside;
      logic [1:0]        neg;
      logic              zero_len;
      logic [ROOT_W-1:0] len;
   } div_side_type;

endpackage

// ----- rtl/core/heightfield_vertex_normal.sv -----
// Heightfield vertex normal: six-triangle fan sum, normalized to Q1.15, fully pipelined.
//
//  channel   ports                       handshake
//  request   start, busy, req_*          taken when start && !busy
//  response  rsp_valid, rsp_*            one-cycle strobe, no backpressure
//  csr       csr_valid, csr_ready, csr_* write when csr_valid && csr_ready
//
// One vertex per cycle; busy stays low and nothing stalls.
// The pipeline holds the 32-step integer square root and the 16-step
// restoring divider, one step per stage.
// Synchronous reset clears valid bits and restores the csr defaults.
module heightfield_vertex_normal (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic        [hvn_pkg::INDEX_BITS-1:0]     req_column,
   input  logic        [hvn_pkg::INDEX_BITS-1:0]     req_row,
   input  logic signed [hvn_pkg::HEIGHT_BITS-1:0]    req_height_center,
   input  logic signed [hvn_pkg::HEIGHT_BITS-1:0]    req_height_right,
   input  logic signed [hvn_pkg::HEIGHT_BITS-1:0]    req_height_top,
   input  logic signed [hvn_pkg::HEIGHT_BITS-1:0]    req_height_top_left,
   input  logic signed [hvn_pkg::HEIGHT_BITS-1:0]    req_height_left,
   input  logic signed [hvn_pkg::HEIGHT_BITS-1:0]    req_height_bottom,
   input  logic signed [hvn_pkg::HEIGHT_BITS-1:0]    req_height_bottom_right,
   output logic                                      rsp_valid,
   output logic signed [hvn_pkg::COMP_W-1:0]         rsp_normal_x,
   output logic signed [hvn_pkg::COMP_W-1:0]         rsp_normal_y,
   output logic signed [hvn_pkg::COMP_W-1:0]         rsp_normal_z,
   output logic                                      rsp_outside_grid,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic        [hvn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic        [hvn_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int HB  = hvn_pkg::HEIGHT_BITS;
   localparam int NW  = hvn_pkg::NORM_W;
   localparam int MW  = hvn_pkg::MAG_W;
   localparam int QW  = hvn_pkg::Q_W;
   localparam int RW  = hvn_pkg::RT_W;
   localparam int NSQ = hvn_pkg::SQ_STEPS;

   // ---------------- configuration ----------------
   logic [hvn_pkg::DIM_W-1:0]   cols_ff, rows_ff;
   logic [hvn_pkg::SPACE_W-1:0] spx_ff, spy_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= hvn_pkg::RESET_COLUMNS;
         rows_ff <= hvn_pkg::RESET_ROWS;
         spx_ff  <= hvn_pkg::RESET_SPACING;
         spy_ff  <= hvn_pkg::RESET_SPACING;
      end else if (csr_valid) begin
         case (hvn_pkg::csr_index_type'(csr_index))
            hvn_pkg::CSR_COLUMNS:   cols_ff <= csr_wdata[hvn_pkg::DIM_W-1:0];
            hvn_pkg::CSR_ROWS:      rows_ff <= csr_wdata[hvn_pkg::DIM_W-1:0];
            hvn_pkg::CSR_SPACING_X: spx_ff  <= csr_wdata;
            hvn_pkg::CSR_SPACING_Y: spy_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: input register ----------------
   logic                           v1_ff;
   logic [hvn_pkg::INDEX_BITS-1:0] col1_ff, row1_ff;
   logic signed [HB-1:0]           h1_ff [0:6];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         col1_ff  <= req_column;
         row1_ff  <= req_row;
         h1_ff[0] <= req_height_center;
         h1_ff[1] <= req_height_right;
         h1_ff[2] <= req_height_top;
         h1_ff[3] <= req_height_top_left;
         h1_ff[4] <= req_height_left;
         h1_ff[5] <= req_height_bottom;
         h1_ff[6] <= req_height_bottom_right;
      end
   end

   // ---------------- stage 2: grid test, height deltas ----------------
   logic                              v2_ff, out2_ff;
   logic [5:0]                        tri2_ff, tri2_in;
   logic signed [hvn_pkg::DZ_W-1:0]   dz2_ff [0:5];
   logic                              out2_in;
   logic                              has_r, has_t, has_l, has_b;
   logic [5:0]                        on2;
   logic [hvn_pkg::DIM_W-1:0]         col_x, row_x;

   always_comb begin
      col_x   = hvn_pkg::DIM_W'(col1_ff);
      row_x   = hvn_pkg::DIM_W'(row1_ff);
      out2_in = (col_x >= cols_ff) || (row_x >= rows_ff);
      has_r   = (col_x + 1'b1) < cols_ff;
      has_t   = (row_x + 1'b1) < rows_ff;
      has_l   = col1_ff != '0;
      has_b   = row1_ff != '0;
      // neighbor order: right, top, top-left, left, bottom, bottom-right
      on2     = {has_r & has_b, has_b, has_l, has_l & has_t, has_t, has_r};
      for (int k = 0; k < 6; k++) begin
         tri2_in[k] = on2[k] & on2[(k + 1) % 6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      out2_ff <= out2_in;
      tri2_ff <= tri2_in;
      for (int k = 0; k < 6; k++) begin
         dz2_ff[k] <= hvn_pkg::DZ_W'(h1_ff[k+1]) - hvn_pkg::DZ_W'(h1_ff[0]);
      end
   end

   // ---------------- stage 3: fan sums of the dz terms ----------------
   logic                              v3_ff, out3_ff;
   logic signed [hvn_pkg::IX_W-1:0]   ix3_ff, iy3_ff, ix3_in, iy3_in;
   logic [hvn_pkg::CNT_W-1:0]         cnt3_ff;
   logic signed [hvn_pkg::IX_W-1:0]   d [0:5];

   always_comb begin
      for (int k = 0; k < 6; k++) d[k] = hvn_pkg::IX_W'(dz2_ff[k]);
      ix3_in = '0;
      iy3_in = '0;
      // x term is sy * sum, y term is sx * sum
      if (tri2_ff[0]) begin ix3_in = ix3_in - d[0];        iy3_in = iy3_in - d[1];        end
      if (tri2_ff[1]) begin ix3_in = ix3_in + d[2] - d[1]; iy3_in = iy3_in - d[1];        end
      if (tri2_ff[2]) begin ix3_in = ix3_in + d[3];        iy3_in = iy3_in + d[3] - d[2]; end
      if (tri2_ff[3]) begin ix3_in = ix3_in + d[3];        iy3_in = iy3_in + d[4];        end
      if (tri2_ff[4]) begin ix3_in = ix3_in + d[4] - d[5]; iy3_in = iy3_in + d[4];        end
      if (tri2_ff[5]) begin ix3_in = ix3_in - d[0];        iy3_in = iy3_in + d[5] - d[0]; end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      out3_ff <= out2_ff;
      ix3_ff  <= ix3_in;
      iy3_ff  <= iy3_in;
      cnt3_ff <= hvn_pkg::CNT_W'($countones(tri2_ff));
   end

   // ---------------- stage 4: spacing products ----------------
   logic                               v4_ff, out4_ff;
   logic signed [MW:0]                 x4_ff, y4_ff;
   logic [2*hvn_pkg::SPACE_W-1:0]      p4_ff;
   logic [hvn_pkg::CNT_W-1:0]          cnt4_ff;
   logic signed [hvn_pkg::PROD_W-1:0]  xp, yp;

   always_comb begin
      xp = hvn_pkg::PROD_W'(ix3_ff) * hvn_pkg::PROD_W'($signed({1'b0, spy_ff}));
      yp = hvn_pkg::PROD_W'(iy3_ff) * hvn_pkg::PROD_W'($signed({1'b0, spx_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      out4_ff <= out3_ff;
      x4_ff   <= $signed(xp[MW:0]);
      y4_ff   <= $signed(yp[MW:0]);
      p4_ff   <= spx_ff * spy_ff;
      cnt4_ff <= cnt3_ff;
   end

   // ---------------- stage 5: z product, magnitudes ----------------
   logic          v5_ff, out5_ff;
   logic [MW-1:0] m5_ff [0:2];
   logic [1:0]    neg5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      out5_ff  <= out4_ff;
      neg5_ff  <= {y4_ff[MW], x4_ff[MW]};
      m5_ff[0] <= x4_ff[MW] ? MW'(-x4_ff) : MW'(x4_ff);
      m5_ff[1] <= y4_ff[MW] ? MW'(-y4_ff) : MW'(y4_ff);
      m5_ff[2] <= MW'(p4_ff) * MW'(cnt4_ff);
   end

   // ---------------- stage 6: normalizing shift count ----------------
   logic                          v6_ff, out6_ff;
   logic [MW-1:0]                 m6_ff [0:2];
   logic [1:0]                    neg6_ff;
   logic [hvn_pkg::SHIFT_W-1:0]   sh6_ff, sh6_in;
   logic [MW-1:0]                 orm;

   always_comb begin
      orm    = m5_ff[0] | m5_ff[1] | m5_ff[2];
      sh6_in = '0;
      for (int i = 0; i < MW - NW; i++) begin
         if (orm[NW+i]) sh6_in = hvn_pkg::SHIFT_W'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      out6_ff <= out5_ff;
      neg6_ff <= neg5_ff;
      sh6_ff  <= sh6_in;
      for (int c = 0; c < 3; c++) m6_ff[c] <= m5_ff[c];
   end

   // ---------------- stage 7: shift ----------------
   logic          v7_ff, out7_ff;
   logic [NW-1:0] n7_ff [0:2];
   logic [1:0]    neg7_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v6_ff;
   end

   always_ff @(posedge clock) begin
      out7_ff <= out6_ff;
      neg7_ff <= neg6_ff;
      for (int c = 0; c < 3; c++) n7_ff[c] <= NW'(m6_ff[c] >> sh6_ff);
   end

   // ---------------- stage 8: squares ----------------
   logic                          v8_ff;
   logic [hvn_pkg::SQR_W-1:0]     sq8_ff [0:2];
   hvn_pkg::sq_side_type          side8_ff;

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else       v8_ff <= v7_ff;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         sq8_ff[c] <= hvn_pkg::SQR_W'(n7_ff[c]) * hvn_pkg::SQR_W'(n7_ff[c]);
      end
      side8_ff.outside <= out7_ff;
      side8_ff.neg     <= neg7_ff;
      side8_ff.mag_x   <= n7_ff[0];
      side8_ff.mag_y   <= n7_ff[1];
      side8_ff.mag_z   <= n7_ff[2];
   end

   // ---------------- stage 9 + square root, one bit pair per stage ----------------
   logic                 sqv_ff   [0:NSQ];
   logic [RW-1:0]        sqn_ff   [0:NSQ];
   logic [RW-1:0]        sqr_ff   [0:NSQ];
   hvn_pkg::sq_side_type sqs_ff   [0:NSQ];

   always_ff @(posedge clock) begin
      if (reset) sqv_ff[0] <= 1'b0;
      else       sqv_ff[0] <= v8_ff;
   end

   always_ff @(posedge clock) begin
      sqn_ff[0] <= RW'(hvn_pkg::SUMSQ_W'(sq8_ff[0]) + hvn_pkg::SUMSQ_W'(sq8_ff[1])
                       + hvn_pkg::SUMSQ_W'(sq8_ff[2]));
      sqr_ff[0] <= '0;
      sqs_ff[0] <= side8_ff;
   end

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NSQ - 1 - k));
      logic [RW-1:0] trial, n_in, r_in;

      always_comb begin
         trial = sqr_ff[k] + BIT;
         if (sqn_ff[k] >= trial) begin
            n_in = sqn_ff[k] - trial;
            r_in = (sqr_ff[k] >> 1) + BIT;
         end else begin
            n_in = sqn_ff[k];
            r_in = sqr_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) sqv_ff[k+1] <= 1'b0;
         else       sqv_ff[k+1] <= sqv_ff[k];
      end

      always_ff @(posedge clock) begin
         sqn_ff[k+1] <= n_in;
         sqr_ff[k+1] <= r_in;
         sqs_ff[k+1] <= sqs_ff[k];
      end
   end

   // ---------------- divider setup: (mag*2^15 + L/2) ----------------
   logic                       dv_ff   [0:QW];
   logic [hvn_pkg::NUM_W-1:0]  drem_ff [0:QW][0:2];
   logic [QW-1:0]              dq_ff   [0:QW][0:2];
   hvn_pkg::div_side_type      ds_ff   [0:QW];
   logic [hvn_pkg::ROOT_W-1:0] root_len;
   logic [NW-1:0]              setup_mag [0:2];

   always_comb begin
      root_len     = sqr_ff[NSQ][hvn_pkg::ROOT_W-1:0];
      setup_mag[0] = sqs_ff[NSQ].mag_x;
      setup_mag[1] = sqs_ff[NSQ].mag_y;
      setup_mag[2] = sqs_ff[NSQ].mag_z;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= sqv_ff[NSQ];
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         drem_ff[0][c] <= (hvn_pkg::NUM_W'(setup_mag[c]) << (QW - 1))
                          + hvn_pkg::NUM_W'(root_len >> 1);
         dq_ff[0][c]   <= '0;
      end
      ds_ff[0].outside  <= sqs_ff[NSQ].outside;
      ds_ff[0].neg      <= sqs_ff[NSQ].neg;
      ds_ff[0].zero_len <= root_len == '0;
      ds_ff[0].len      <= root_len;
   end

   // restoring divide, quotient bit QW-1-d in stage d
   for (genvar d = 0; d < QW; d++) begin : g_div
      localparam int QB = QW - 1 - d;
      logic [hvn_pkg::NUM_W-1:0] dsub;
      logic [hvn_pkg::NUM_W-1:0] rem_in [0:2];
      logic [QW-1:0]             q_in   [0:2];

      always_comb begin
         dsub = hvn_pkg::NUM_W'(ds_ff[d].len) << QB;
         for (int c = 0; c < 3; c++) begin
            rem_in[c] = drem_ff[d][c];
            q_in[c]   = dq_ff[d][c];
            if (drem_ff[d][c] >= dsub) begin
               rem_in[c]  = drem_ff[d][c] - dsub;
               q_in[c][QB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[d+1] <= 1'b0;
         else       dv_ff[d+1] <= dv_ff[d];
      end

      always_ff @(posedge clock) begin
         for (int c = 0; c < 3; c++) begin
            drem_ff[d+1][c] <= rem_in[c];
            dq_ff[d+1][c]   <= q_in[c];
         end
         ds_ff[d+1] <= ds_ff[d];
      end
   end

   // ---------------- output: saturate, sign, special cases ----------------
   logic                     rsp_valid_ff;
   logic signed [QW-1:0]     nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic                     og_ff;
   logic signed [QW-1:0]     comp [0:2];
   logic [QW-2:0]            qs;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qs = (dq_ff[QW][c] > QW'(hvn_pkg::Q15_MAX)) ? hvn_pkg::Q15_MAX
                                                    : dq_ff[QW][c][QW-2:0];
         comp[c] = $signed({1'b0, qs});
      end
      // z is never negative
      if (ds_ff[QW].neg[0]) comp[0] = -comp[0];
      if (ds_ff[QW].neg[1]) comp[1] = -comp[1];
      if (ds_ff[QW].outside) begin
         nx_in = '0;
         ny_in = '0;
         nz_in = '0;
      end else if (ds_ff[QW].zero_len) begin
         // zero-length sum, as for an empty fan: straight up
         nx_in = '0;
         ny_in = '0;
         nz_in = $signed({1'b0, hvn_pkg::Q15_MAX});
      end else begin
         nx_in = comp[0];
         ny_in = comp[1];
         nz_in = comp[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= dv_ff[QW];
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      nz_ff <= nz_in;
      og_ff <= ds_ff[QW].outside;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_normal_x     = nx_ff;
   assign rsp_normal_y     = ny_ff;
   assign rsp_normal_z     = nz_ff;
   assign rsp_outside_grid = og_ff;

endmodule

// ----- sim/heightfield_vertex_normal_tb.sv -----
// Self-checking testbench for the heightfield vertex normal block.
module heightfield_vertex_normal_tb;

   typedef struct packed {
      logic [hvn_pkg::INDEX_BITS-1:0]        column;
      logic [hvn_pkg::INDEX_BITS-1:0]        row;
      logic [6:0][hvn_pkg::HEIGHT_BITS-1:0]  heights;  // center, r, t, tl, l, b, br
   } vertex_type;

   typedef struct packed {
      logic signed [hvn_pkg::COMP_W-1:0] nx;
      logic signed [hvn_pkg::COMP_W-1:0] ny;
      logic signed [hvn_pkg::COMP_W-1:0] nz;
      logic                              outside;
   } normal_type;

   typedef struct packed {
      vertex_type v;
      logic       typed;
      normal_type n;
   } stim_row_type;

   localparam int LATENCY_WAIT = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_PER_SETTING = 185;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [hvn_pkg::INDEX_BITS-1:0] req_column, req_row;
   logic signed [hvn_pkg::HEIGHT_BITS-1:0] req_height_center, req_height_right;
   logic signed [hvn_pkg::HEIGHT_BITS-1:0] req_height_top;
   logic signed [hvn_pkg::HEIGHT_BITS-1:0] req_height_top_left, req_height_left;
   logic signed [hvn_pkg::HEIGHT_BITS-1:0] req_height_bottom, req_height_bottom_right;
   logic rsp_valid;
   logic signed [hvn_pkg::COMP_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_outside_grid;
   logic csr_valid;
   logic csr_ready;
   hvn_pkg::csr_index_type csr_index;
   logic [hvn_pkg::CSR_DATA_W-1:0] csr_wdata;

   heightfield_vertex_normal dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_column(req_column), .req_row(req_row),
      .req_height_center(req_height_center), .req_height_right(req_height_right),
      .req_height_top(req_height_top), .req_height_top_left(req_height_top_left),
      .req_height_left(req_height_left), .req_height_bottom(req_height_bottom),
      .req_height_bottom_right(req_height_bottom_right),
      .rsp_valid(rsp_valid), .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_outside_grid(rsp_outside_grid),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   int grid_cols, grid_rows, pitch_x, pitch_y;
   normal_type pending_normals[$];
   int mismatches;
   int cycle_count;
   int idle_pct;
   int quiet_left;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("heightfield_vertex_normal: mismatch");
         $finish;
      end
   end

   function automatic logic [15:0] q15_of(longint c, longint unsigned mag, longint unsigned len);
      longint unsigned q;
      q = (mag * 32768 + len / 2) / len;
      if (q > 32767) q = 32767;
      if (c < 0) q = -q;
      return q[15:0];
   endfunction

   function automatic normal_type fan_normal(vertex_type v);
      int ox[6] = '{1, 0, -1, -1, 0, 1};
      int oy[6] = '{0, 1, 1, 0, -1, -1};
      longint ex[6], ey[6], ez[6];
      bit on_grid[6];
      longint hc, sx, sy, sz, ni, nj;
      longint unsigned mx, my, mz, m, n, res, bitv;
      bit any;
      int k, j;
      normal_type r;
      r = '0;
      if (v.column >= grid_cols || v.row >= grid_rows) begin
         r.outside = 1'b1;
         return r;
      end
      hc = longint'($signed(v.heights[0]));
      for (k = 0; k < 6; k++) begin
         ni = longint'(v.column) + ox[k];
         nj = longint'(v.row) + oy[k];
         on_grid[k] = ni >= 0 && nj >= 0 && ni < grid_cols && nj < grid_rows;
         ex[k] = ox[k] * longint'(pitch_x);
         ey[k] = oy[k] * longint'(pitch_y);
         ez[k] = longint'($signed(v.heights[k+1])) - hc;
      end
      sx = 0; sy = 0; sz = 0; any = 0;
      for (k = 0; k < 6; k++) begin
         j = (k + 1) % 6;
         if (on_grid[k] && on_grid[j]) begin
            sx += ey[k] * ez[j] - ez[k] * ey[j];
            sy += ez[k] * ex[j] - ex[k] * ez[j];
            sz += ex[k] * ey[j] - ey[k] * ex[j];
            any = 1;
         end
      end
      mx = sx < 0 ? -sx : sx;
      my = sy < 0 ? -sy : sy;
      mz = sz < 0 ? -sz : sz;
      m = mx > my ? mx : my;
      if (mz > m) m = mz;
      while (m >= (64'd1 << 30)) begin
         m >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
      end
      // bitwise integer square root
      n = mx * mx + my * my + mz * mz;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      if (!any || res == 0) begin
         r.nz = 16'sd32767;
         return r;
      end
      r.nx = q15_of(sx, mx, res);
      r.ny = q15_of(sy, my, res);
      r.nz = q15_of(sz, mz, res);
      return r;
   endfunction

   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_valid) begin
         if (pending_normals.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result x=%0d y=%0d z=%0d out=%0b", rsp_normal_x,
                        rsp_normal_y, rsp_normal_z, rsp_outside_grid);
            mismatches++;
         end else begin
            want = pending_normals.pop_front();
            if (want.nx !== rsp_normal_x || want.ny !== rsp_normal_y ||
                want.nz !== rsp_normal_z || want.outside !== rsp_outside_grid) begin
               if (mismatches < 10)
                  $display("normal: expected %0d %0d %0d out=%0b, got %0d %0d %0d out=%0b",
                           want.nx, want.ny, want.nz, want.outside, rsp_normal_x,
                           rsp_normal_y, rsp_normal_z, rsp_outside_grid);
               mismatches++;
            end
         end
      end
   end

   task automatic write_reg(hvn_pkg::csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[hvn_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         hvn_pkg::CSR_COLUMNS:   grid_cols = value & 32'h1FFF;
         hvn_pkg::CSR_ROWS:      grid_rows = value & 32'h1FFF;
         hvn_pkg::CSR_SPACING_X: pitch_x = value & 32'hFFFF;
         hvn_pkg::CSR_SPACING_Y: pitch_y = value & 32'hFFFF;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   // leaves start high after the accepting edge; caller lowers it or sends again
   task automatic send_vertex(vertex_type v, logic typed, normal_type n);
      if (quiet_left > 0) begin
         quiet_left--;
      end else if ($urandom_range(0, 39) == 0) begin
         quiet_left = 30;
      end else begin
         while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_column <= v.column;
      req_row <= v.row;
      req_height_center <= v.heights[0];
      req_height_right <= v.heights[1];
      req_height_top <= v.heights[2];
      req_height_top_left <= v.heights[3];
      req_height_left <= v.heights[4];
      req_height_bottom <= v.heights[5];
      req_height_bottom_right <= v.heights[6];
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_normals.push_back(typed ? n : fan_normal(v));
   endtask

   function automatic int pick_index(int limit);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom_range(0, 4095);
      if (r == 1) return limit > 4095 ? 4095 : limit;        // just off the grid, unless the grid is wider than 4095
      if (r == 2) return 0;
      if (r == 3) return limit - 1 > 4095 ? 4095 : limit - 1;
      if (r == 4) return limit > 1 ? 1 : 0;
      return $urandom_range(0, limit - 1 > 4095 ? 4095 : limit - 1);
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type v;
      int base, mode, k;
      v.column = hvn_pkg::INDEX_BITS'(pick_index(grid_cols));
      v.row = hvn_pkg::INDEX_BITS'(pick_index(grid_rows));
      mode = $urandom_range(0, 3);
      base = int'($signed(16'($urandom)));
      for (k = 0; k < 7; k++) begin
         case (mode)
            0: v.heights[k] = 16'($urandom);
            1: v.heights[k] = 16'(base + $signed($urandom_range(0, 64)) - 32);
            2: v.heights[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: v.heights[k] = 16'(base);
         endcase
      end
      return v;
   endfunction

   stim_row_type directed[$];

   function automatic stim_row_type make_row(int c, int r, int h0, int h1, int h2, int h3,
                                             int h4, int h5, int h6, logic typed,
                                             int nx, int ny, int nz, logic out);
      stim_row_type s;
      s.v.column = hvn_pkg::INDEX_BITS'(c);
      s.v.row = hvn_pkg::INDEX_BITS'(r);
      s.v.heights = {16'(h6), 16'(h5), 16'(h4), 16'(h3), 16'(h2), 16'(h1), 16'(h0)};
      s.typed = typed;
      s.n.nx = hvn_pkg::COMP_W'(nx);
      s.n.ny = hvn_pkg::COMP_W'(ny);
      s.n.nz = hvn_pkg::COMP_W'(nz);
      s.n.outside = out;
      return s;
   endfunction

   int settings[8][4] = '{
      '{4096, 4096, 65535, 65535},
      '{1, 1, 1, 1},
      '{1, 9, 300, 2},
      '{7, 1, 5, 65535},
      '{2, 2, 1, 65535},
      '{4096, 3, 17, 1},
      '{33, 4096, 65535, 1},
      '{256, 256, 1, 1}
   };

   initial begin
      normal_type none;
      int p, k;
      none = '0;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = hvn_pkg::CSR_COLUMNS;
      csr_wdata = '0;
      req_column = '0; req_row = '0;
      req_height_center = '0; req_height_right = '0; req_height_top = '0;
      req_height_top_left = '0; req_height_left = '0; req_height_bottom = '0;
      req_height_bottom_right = '0;
      cycle_count = 0;
      mismatches = 0;
      quiet_left = 0;
      idle_pct = 18;
      grid_cols = 256; grid_rows = 256; pitch_x = 1; pitch_y = 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // flat ground points straight up; off-grid vertices report zeros
      directed.push_back(make_row(10, 10, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 32767, 0));
      directed.push_back(make_row(0, 0, 5, 5, 5, 5, 5, 5, 5, 1, 0, 0, 32767, 0));
      directed.push_back(make_row(255, 255, -9, -9, -9, -9, -9, -9, -9, 1, 0, 0, 32767, 0));
      directed.push_back(make_row(256, 0, 1, 2, 3, 4, 5, 6, 7, 1, 0, 0, 0, 1));
      directed.push_back(make_row(0, 256, 1, 2, 3, 4, 5, 6, 7, 1, 0, 0, 0, 1));
      directed.push_back(make_row(4095, 4095, -1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
      directed.push_back(make_row(10, 10, 32767, -32768, -32768, -32768, -32768, -32768,
                                  -32768, 0, 0, 0, 0, 0));
      directed.push_back(make_row(10, 10, -32768, 32767, 32767, 32767, 32767, 32767,
                                  32767, 0, 0, 0, 0, 0));
      directed.push_back(make_row(10, 10, 0, 32767, -32768, 32767, -32768, 32767,
                                  -32768, 0, 0, 0, 0, 0));
      directed.push_back(make_row(0, 0, 0, 100, -100, 7, 7, 7, 7, 0, 0, 0, 0, 0));
      directed.push_back(make_row(255, 0, 0, 3, 9, -4, 12, 1, 1, 0, 0, 0, 0, 0));
      directed.push_back(make_row(0, 255, 0, 3, 9, -4, 12, 1, 1, 0, 0, 0, 0, 0));
      directed.push_back(make_row(255, 255, 0, 3, 9, -4, 12, 1, 1, 0, 0, 0, 0, 0));
      directed.push_back(make_row(100, 0, 40, 41, 60, 2, -30, 9, 9, 0, 0, 0, 0, 0));
      directed.push_back(make_row(0, 100, 40, 41, 60, 2, -30, 9, 9, 0, 0, 0, 0, 0));
      directed.push_back(make_row(255, 100, 40, 41, 60, 2, -30, 9, 9, 0, 0, 0, 0, 0));
      directed.push_back(make_row(100, 255, 40, 41, 60, 2, -30, 9, 9, 0, 0, 0, 0, 0));
      directed.push_back(make_row(128, 64, 1, 2, 3, 4, 5, 6, 7, 0, 0, 0, 0, 0));
      foreach (directed[k])
         send_vertex(directed[k].v, directed[k].typed, directed[k].n);
      start <= 1'b0;
      drain();

      for (p = 0; p < 8; p++) begin
         idle_pct = p < 3 ? 18 : (p < 6 ? 60 : 0);
         write_reg(hvn_pkg::CSR_COLUMNS, settings[p][0]);
         write_reg(hvn_pkg::CSR_ROWS, settings[p][1]);
         write_reg(hvn_pkg::CSR_SPACING_X, settings[p][2]);
         write_reg(hvn_pkg::CSR_SPACING_Y, settings[p][3]);
         for (k = 0; k < RANDOM_PER_SETTING; k++) begin
            send_vertex(random_vertex(), 1'b0, none);
            if (k == RANDOM_PER_SETTING / 2) begin
               // hold off until the pipeline is empty
               start <= 1'b0;
               while (pending_normals.size() != 0) @(posedge clock);
            end
         end
         start <= 1'b0;
         drain();
      end

      if (mismatches == 0 && pending_normals.size() == 0) begin
         $display("heightfield_vertex_normal: match");
      end else begin
         $display("heightfield_vertex_normal: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/hvn_pkg.sv
rtl/core/heightfield_vertex_normal.sv
sim/heightfield_vertex_normal_tb.sv
